@@ design/sss_pkg.sv @@
// shared types, codes and constants for the sparse set block
package sss_pkg;

  localparam int DEF_MAX_IDS  = 1024;
  localparam int DEF_TAG_BITS = 16;

  localparam int ACT_W      = 2;
  localparam int IDX_W      = 10;
  localparam int TAG_IN_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 10;
  localparam int CNT_OUT_W  = 11;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_REMOVED = 3'd2,
    ST_IGNORED = 3'd3,
    ST_CLEARED = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CHK,
    S_MOVE,
    S_UNMAP,
    S_CLR_RD,
    S_CLR_WR,
    S_FIN
  } state_t;

  // map write sources
  typedef enum logic [2:0] {
    MAPW_APPEND,
    MAPW_MOVE,
    MAPW_UNMAP,
    MAPW_INIT,
    MAPW_CLEAR
  } map_wsel_t;

  // member array write sources
  typedef enum logic [1:0] {
    MEMW_UPDATE,
    MEMW_APPEND,
    MEMW_MOVE
  } mem_wsel_t;

  // member array read address sources
  typedef enum logic [1:0] {
    MEMR_SLOT,
    MEMR_LAST,
    MEMR_WALK
  } mem_rsel_t;

  // result slot sources
  typedef enum logic [1:0] {
    RS_ZERO,
    RS_MAP,
    RS_COUNT
  } res_sel_t;

  typedef struct packed {
    logic      capture;
    logic      map_wr;
    map_wsel_t map_wsel;
    logic      mem_wr;
    mem_wsel_t mem_wsel;
    logic      mem_rd;
    mem_rsel_t mem_rsel;
    logic      count_inc;
    logic      count_dec;
    logic      count_clr;
    logic      walk_clr;
    logic      walk_inc;
    logic      res_load;
    status_t   res_status;
    res_sel_t  res_sel;
    logic      out_load;
  } sss_cmd_t;

  typedef struct packed {
    action_t act;
    logic    in_range;
    logic    map_hit;
    logic    full;
    logic    rm_ok;
    logic    rm_match;
    logic    count_zero;
    logic    walk_last_init;
    logic    walk_last_clr;
    logic    out_busy;
  } sss_stat_t;

endpackage

@@ design/sparse_set_swap_remove.sv @@
// sparse set of object ids with swap-remove, top level
// result registered via capture, execute and finish states for add, update, range, ignored;
// a remove that finds its id adds a check state, and a move and an unmap state on a match;
// clear adds a read and a write state per member; finish holds while the last result waits
// one item at a time, set by the dependent reads and writes of the map and member memories;
// after reset all MAX_IDS map entries are swept with in_ready low, count is zero
module sparse_set_swap_remove
  import sss_pkg::*;
#(
  parameter int MAX_IDS  = DEF_MAX_IDS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [IDX_W-1:0]      in_id_index,
  input  logic [TAG_IN_W-1:0]   in_id_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [CNT_OUT_W-1:0]  out_member_count
);

  sss_cmd_t  cmd;
  sss_stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_datapath #(
    .MAX_IDS  (MAX_IDS),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_id_index      (in_id_index),
    .in_id_tag        (in_id_tag),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_member_count (out_member_count),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

@@ design/sss_ctrl.sv @@
// controller state machine for the sparse set block
module sss_ctrl
  import sss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sss_stat_t stat,
  output sss_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.map_wsel   = MAPW_INIT;
    cmd.mem_wsel   = MEMW_UPDATE;
    cmd.mem_rsel   = MEMR_SLOT;
    cmd.res_status = ST_IGNORED;
    cmd.res_sel    = RS_ZERO;
    case (state_r)
      S_INIT: begin
        // map sweep after reset
        cmd.map_wr   = 1'b1;
        cmd.map_wsel = MAPW_INIT;
        cmd.walk_inc = 1'b1;
        if (stat.walk_last_init) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.walk_clr = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_FIN;
        case (stat.act)
          ACT_CLEAR: begin
            cmd.res_status = ST_CLEARED;
            if (!stat.count_zero) begin
              state_nxt = S_CLR_RD;
            end
          end
          ACT_ADD: begin
            if (!stat.in_range) begin
              cmd.res_status = ST_RANGE;
            end else if (stat.map_hit) begin
              cmd.mem_wr     = 1'b1;
              cmd.mem_wsel   = MEMW_UPDATE;
              cmd.res_status = ST_UPDATED;
              cmd.res_sel    = RS_MAP;
            end else if (!stat.full) begin
              cmd.map_wr     = 1'b1;
              cmd.map_wsel   = MAPW_APPEND;
              cmd.mem_wr     = 1'b1;
              cmd.mem_wsel   = MEMW_APPEND;
              cmd.count_inc  = 1'b1;
              cmd.res_status = ST_ADDED;
              cmd.res_sel    = RS_COUNT;
            end
          end
          ACT_REMOVE: begin
            if (!stat.in_range) begin
              cmd.res_status = ST_RANGE;
            end else if (stat.rm_ok) begin
              cmd.mem_rd   = 1'b1;
              cmd.mem_rsel = MEMR_SLOT;
              state_nxt    = S_CHK;
            end
          end
          default: begin
            cmd.res_status = ST_IGNORED;
          end
        endcase
      end
      S_CHK: begin
        if (stat.rm_match) begin
          cmd.mem_rd   = 1'b1;
          cmd.mem_rsel = MEMR_LAST;
          state_nxt    = S_MOVE;
        end else begin
          cmd.res_load = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_MOVE: begin
        // last member into the freed slot
        cmd.mem_wr    = 1'b1;
        cmd.mem_wsel  = MEMW_MOVE;
        cmd.map_wr    = 1'b1;
        cmd.map_wsel  = MAPW_MOVE;
        cmd.count_dec = 1'b1;
        state_nxt     = S_UNMAP;
      end
      S_UNMAP: begin
        cmd.map_wr     = 1'b1;
        cmd.map_wsel   = MAPW_UNMAP;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_REMOVED;
        cmd.res_sel    = RS_MAP;
        state_nxt      = S_FIN;
      end
      S_CLR_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.mem_rsel = MEMR_WALK;
        state_nxt    = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd.map_wr   = 1'b1;
        cmd.map_wsel = MAPW_CLEAR;
        if (stat.walk_last_clr) begin
          cmd.count_clr = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.walk_inc = 1'b1;
          state_nxt    = S_CLR_RD;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/sss_datapath.sv @@
// map and member memories, counters and result registers of the sparse set block
module sss_datapath
  import sss_pkg::*;
#(
  parameter int MAX_IDS  = DEF_MAX_IDS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [IDX_W-1:0]      in_id_index,
  input  logic [TAG_IN_W-1:0]   in_id_tag,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [CNT_OUT_W-1:0]  out_member_count,
  input  sss_cmd_t              cmd,
  output sss_stat_t             stat
);

  localparam int SW = $clog2(MAX_IDS);
  localparam int CW = $clog2(MAX_IDS + 1);

  // map entry: present bit over slot
  logic [SW:0]         map_mem [MAX_IDS];
  logic [IDX_W-1:0]    midx_mem [MAX_IDS];
  logic [TAG_BITS-1:0] mtag_mem [MAX_IDS];

  action_t             act_r;
  logic [IDX_W-1:0]    idx_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [SW:0]         map_rd_r;
  logic [IDX_W-1:0]    midx_rd_r;
  logic [TAG_BITS-1:0] mtag_rd_r;
  logic [CW-1:0]       count_r;
  logic [SW-1:0]       walk_r;
  status_t             res_status_r;
  logic [SW-1:0]       res_slot_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SW-1:0]       out_slot_r;
  logic [CW-1:0]       out_count_r;

  logic                map_present;
  logic [SW-1:0]       map_slot;
  logic [SW-1:0]       last_slot;
  logic                moved_ok;
  logic                map_we;
  logic [SW-1:0]       map_waddr;
  logic [SW:0]         map_wdata;
  logic [SW-1:0]       mem_waddr;
  logic [IDX_W-1:0]    midx_wdata;
  logic [TAG_BITS-1:0] mtag_wdata;
  logic [SW-1:0]       mem_raddr;

  assign map_present = map_rd_r[SW];
  assign map_slot    = map_rd_r[SW-1:0];
  assign last_slot   = SW'(count_r - CW'(1));
  assign moved_ok    = 32'(midx_rd_r) < 32'(MAX_IDS);

  assign stat.act            = act_r;
  assign stat.in_range       = 32'(idx_r) < 32'(MAX_IDS);
  assign stat.map_hit        = map_present && (32'(map_slot) < 32'(MAX_IDS));
  assign stat.full           = 32'(count_r) >= 32'(MAX_IDS);
  assign stat.rm_ok          = map_present && (CW'(map_slot) < count_r)
                               && (32'(map_slot) < 32'(MAX_IDS));
  assign stat.rm_match       = (midx_rd_r == idx_r) && (mtag_rd_r == tag_r);
  assign stat.count_zero     = (count_r == '0);
  assign stat.walk_last_init = (walk_r == SW'(MAX_IDS - 1));
  assign stat.walk_last_clr  = ((CW'(walk_r) + CW'(1)) == count_r);
  assign stat.out_busy       = out_valid_r && !out_ready;

  // map write port
  always_comb begin
    map_we    = cmd.map_wr;
    map_waddr = '0;
    map_wdata = '0;
    case (cmd.map_wsel)
      MAPW_APPEND: begin
        map_waddr = SW'(idx_r);
        map_wdata = {1'b1, SW'(count_r)};
      end
      MAPW_MOVE: begin
        map_we    = cmd.map_wr && moved_ok;
        map_waddr = SW'(midx_rd_r);
        map_wdata = {1'b1, map_slot};
      end
      MAPW_UNMAP: begin
        map_waddr = SW'(idx_r);
      end
      MAPW_INIT: begin
        map_waddr = walk_r;
      end
      MAPW_CLEAR: begin
        map_we    = cmd.map_wr && moved_ok;
        map_waddr = SW'(midx_rd_r);
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd.capture) begin
      map_rd_r <= map_mem[SW'(in_id_index)];
    end
  end

  // member arrays
  always_comb begin
    mem_waddr  = map_slot;
    midx_wdata = idx_r;
    mtag_wdata = tag_r;
    case (cmd.mem_wsel)
      MEMW_UPDATE: mem_waddr = map_slot;
      MEMW_APPEND: mem_waddr = SW'(count_r);
      MEMW_MOVE: begin
        mem_waddr  = map_slot;
        midx_wdata = midx_rd_r;
        mtag_wdata = mtag_rd_r;
      end
      default: mem_waddr = map_slot;
    endcase
    case (cmd.mem_rsel)
      MEMR_SLOT: mem_raddr = map_slot;
      MEMR_LAST: mem_raddr = last_slot;
      MEMR_WALK: mem_raddr = walk_r;
      default:   mem_raddr = map_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      midx_mem[mem_waddr] <= midx_wdata;
      mtag_mem[mem_waddr] <= mtag_wdata;
    end
    if (cmd.mem_rd) begin
      midx_rd_r <= midx_mem[mem_raddr];
      mtag_rd_r <= mtag_mem[mem_raddr];
    end
  end

  // captured item and result staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      idx_r <= in_id_index;
      tag_r <= TAG_BITS'(in_id_tag);
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_sel)
        RS_MAP:   res_slot_r <= map_slot;
        RS_COUNT: res_slot_r <= SW'(count_r);
        default:  res_slot_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_count_r  <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count_clr) begin
        count_r <= '0;
      end else if (cmd.count_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.walk_clr) begin
        walk_r <= '0;
      end else if (cmd.walk_inc) begin
        walk_r <= walk_r + SW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = SLOT_OUT_W'(out_slot_r);
  assign out_member_count = CNT_OUT_W'(out_count_r);

endmodule

@@ sim/sparse_set_swap_remove_tb.sv @@
// self-checking regression bench for the sparse set swap-remove block
`timescale 1ns / 100ps

module sparse_set_swap_remove_tb;
  import sss_pkg::*;

  localparam int CAPACITY         = DEF_MAX_IDS;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 13;
  localparam int PHASE_ITEMS      = 100;

  typedef struct {
    status_t                status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [CNT_OUT_W-1:0]   count;
  } set_result_t;

  // mirror of the map and member arrays, plus the results still owed by the block
  class id_set_tracker;
    bit                  present[CAPACITY];
    bit [IDX_W-1:0]      slot_of[CAPACITY];
    bit [IDX_W-1:0]      member_idx[CAPACITY];
    bit [TAG_IN_W-1:0]   member_tag[CAPACITY];
    int unsigned         members;
    set_result_t         pending_results[$];
    int unsigned         mismatches;

    function new();
      members    = 0;
      mismatches = 0;
      foreach (present[i]) present[i] = 1'b0;
    endfunction

    task flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task owe(input status_t st, input int unsigned sl);
      set_result_t res;
      res.status = st;
      res.slot   = sl[SLOT_OUT_W-1:0];
      res.count  = members[CNT_OUT_W-1:0];
      pending_results.insert(pending_results.size(), res);
    endtask

    task apply_op(input action_t act, input logic [IDX_W-1:0] idx,
                  input logic [TAG_IN_W-1:0] tag);
      int unsigned pos;
      int unsigned last;
      bit [IDX_W-1:0] moved;
      case (act)
        ACT_CLEAR: begin
          for (int i = 0; i < members; i++) present[member_idx[i]] = 1'b0;
          members = 0;
          owe(ST_CLEARED, 0);
        end
        ACT_NONE: owe(ST_IGNORED, 0);
        ACT_ADD: begin
          if (idx >= CAPACITY) begin
            owe(ST_RANGE, 0);
          end else if (present[idx]) begin
            member_idx[slot_of[idx]] = idx;
            member_tag[slot_of[idx]] = tag;
            owe(ST_UPDATED, slot_of[idx]);
          end else if (members >= CAPACITY) begin
            owe(ST_IGNORED, 0);
          end else begin
            present[idx]        = 1'b1;
            slot_of[idx]        = members[IDX_W-1:0];
            member_idx[members] = idx;
            member_tag[members] = tag;
            members++;
            owe(ST_ADDED, slot_of[idx]);
          end
        end
        default: begin
          if (idx >= CAPACITY) begin
            owe(ST_RANGE, 0);
          end else if (!present[idx] || slot_of[idx] >= members ||
                       member_idx[slot_of[idx]] != idx ||
                       member_tag[slot_of[idx]] != tag) begin
            owe(ST_IGNORED, 0);
          end else begin
            // swap the last member into the freed slot and repoint its map entry
            pos             = slot_of[idx];
            last            = members - 1;
            moved           = member_idx[last];
            member_idx[pos] = moved;
            member_tag[pos] = member_tag[last];
            present[moved]  = 1'b1;
            slot_of[moved]  = pos[IDX_W-1:0];
            members         = last;
            present[idx]    = 1'b0;
            owe(ST_REMOVED, pos);
          end
        end
      endcase
    endtask

    task compare_result(input logic [STATUS_W-1:0] st, input logic [SLOT_OUT_W-1:0] sl,
                        input logic [CNT_OUT_W-1:0] cnt);
      set_result_t exp;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result st=%0d slot=%0d count=%0d with nothing outstanding",
                                st, sl, cnt));
      end else begin
        exp = pending_results.pop_front();
        if (st !== exp.status)
          flag_mismatch($sformatf("status %0d, want %0d", st, exp.status));
        if (sl !== exp.slot)
          flag_mismatch($sformatf("slot %0d, want %0d", sl, exp.slot));
        if (cnt !== exp.count)
          flag_mismatch($sformatf("member_count %0d, want %0d", cnt, exp.count));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ACT_W-1:0]      in_action;
  logic [IDX_W-1:0]      in_id_index;
  logic [TAG_IN_W-1:0]   in_id_tag;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [CNT_OUT_W-1:0]  out_member_count;

  id_set_tracker tracker = new();
  int  send_mode;
  int  sink_mode;
  bit  sink_hold_req;

  sparse_set_swap_remove dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_id_index      (in_id_index),
    .in_id_tag        (in_id_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_member_count (out_member_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("sparse_set_swap_remove regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.compare_result(out_status, out_slot, out_member_count);
  end

  // result side: random back-pressure, or one long hold-off on request
  initial begin : result_sink
    int r;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(posedge clk);
      end else if (sink_mode == 0) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(8, 30)) @(posedge clk);
        end else begin
          out_ready <= (r >= 25);
        end
      end
    end
  end

  // holds the transfer until the block takes it, then books it in the tracker
  task automatic offer_op(input logic [ACT_W-1:0] a, input logic [IDX_W-1:0] idx,
                          input logic [TAG_IN_W-1:0] tag);
    in_valid    <= 1'b1;
    in_action   <= a;
    in_id_index <= idx;
    in_id_tag   <= tag;
    do @(posedge clk); while (!in_ready);
    tracker.apply_op(action_t'(a), idx, tag);
  endtask

  task automatic hold_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_mode == 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin : stimulus
    int                  r;
    int                  k;
    int                  add_pct;
    int                  guard;
    logic [ACT_W-1:0]    a;
    logic [IDX_W-1:0]    idx;
    logic [TAG_IN_W-1:0] tag;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_NONE;
    in_id_index   <= '0;
    in_id_tag     <= '0;
    send_mode     = 1;
    sink_mode     = 1;
    sink_hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty clear, stale removes, updates, swaps from the middle and the tail
    offer_op(ACT_CLEAR,  10'h3ff, 16'hffff); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h000, 16'h0000); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h000, 16'h0000); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h3ff, 16'hffff); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h000, 16'h1234); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h000, 16'h0000); hold_sender(sender_gap());
    offer_op(ACT_NONE,   10'h000, 16'h1234); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h155, 16'haaaa); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h2aa, 16'h5555); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h000, 16'h1234); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h2aa, 16'h5555); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h155, 16'haaaa); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h3ff, 16'hffff); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h3ff, 16'hffff); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h005, 16'h0001);
    offer_op(ACT_ADD,    10'h006, 16'h0002);
    offer_op(ACT_ADD,    10'h007, 16'h0003);
    offer_op(ACT_CLEAR,  10'h000, 16'h0000); hold_sender(sender_gap());
    offer_op(ACT_ADD,    10'h005, 16'h0001); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h006, 16'h0002); hold_sender(sender_gap());
    offer_op(ACT_NONE,   10'h3ff, 16'hffff); hold_sender(sender_gap());
    offer_op(ACT_REMOVE, 10'h005, 16'h0001); hold_sender(sender_gap());

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      send_mode = (phase % 4 == 1) ? 0 : 1;
      sink_mode = (phase % 5 == 2) ? 0 : 1;
      case ($urandom_range(0, 2))
        0:       add_pct = 70;
        1:       add_pct = 50;
        default: add_pct = 35;
      endcase
      if (phase == 3) begin
        // sender keeps offering while the sink is held off, so the block backs up
        send_mode     = 0;
        sink_hold_req = 1'b1;
      end
      if (phase == 6) add_pct = 92;
      if (phase == 8) begin
        // drain fully before carrying on
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
          0:       tag = '0;
          1:       tag = '1;
          default: tag = TAG_IN_W'($urandom_range(0, 65535));
        endcase
        idx = IDX_W'($urandom_range(0, CAPACITY - 1));
        if (r < add_pct) begin
          a = ACT_ADD;
          if (tracker.members != 0 && $urandom_range(0, 99) < 40) begin
            k   = $urandom_range(0, tracker.members - 1);
            idx = tracker.member_idx[k];
          end
        end else if (r < 96) begin
          a = ACT_REMOVE;
          k = $urandom_range(0, 99);
          if (tracker.members != 0 && k < 80) begin
            idx = tracker.member_idx[$urandom_range(0, tracker.members - 1)];
            tag = tracker.member_tag[tracker.slot_of[idx]];
            if (k >= 70) tag = tag ^ TAG_IN_W'($urandom_range(1, 65535));
          end
        end else if (r < 98) begin
          a = ACT_NONE;
        end else begin
          a = ACT_CLEAR;
        end
        offer_op(a, idx, tag);
        hold_sender(sender_gap());
      end
    end

    sink_mode = 0;
    in_valid <= 1'b0;
    guard = 0;
    while (tracker.pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (tracker.pending_results.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.pending_results.size()));
    if (tracker.mismatches == 0)
      $display("sparse_set_swap_remove regression: pass");
    else
      $display("sparse_set_swap_remove regression: fail");
    $finish;
  end

endmodule

@@ sparse_set_swap_remove.f @@
design/sss_pkg.sv
design/sss_ctrl.sv
design/sss_datapath.sv
design/sparse_set_swap_remove.sv
sim/sparse_set_swap_remove_tb.sv
